/* src/sync_byte_frame_parser_defines.svh */
// assertion macros for the byte frame parser
// used by the top level; relies on i_clk and i_rst_n in the including module
`ifndef SYNC_BYTE_FRAME_PARSER_DEFINES_SVH
`define SYNC_BYTE_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SBFP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sbfp assertion failed");
// condition must never be true outside reset
`define SBFP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("sbfp forbidden condition seen");
`else
`define SBFP_ASSERT(label, prop)
`define SBFP_ASSERT_NEVER(label, cond)
`endif

`endif

/* src/sbfp_pkg.sv */
// shared types and constants of the byte frame parser
// no dependencies
package sbfp_pkg;

    // frame marker byte
    localparam logic [7:0] HEADER_BYTE = 8'h68;

    // register map
    localparam int unsigned      REG_ADDR_W       = 3;
    localparam logic [0:0]       REG_PAYLOAD_LEN  = 1'b0;
    localparam logic [7:0]       PAYLOAD_LEN_RST  = 8'd9;

    // parser phases; unused codes behave as idle
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_ADDR = 3'd2,
        PH_CMD  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    // state kept between beats
    typedef struct packed {
        t_phase     phase;
        logic [7:0] length;
        logic [7:0] address;
        logic [7:0] command;
        logic [7:0] sum;
        logic [7:0] count;
    } t_parse_state;

    // one result beat
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       checksum_ok;
        logic [7:0] frame_address;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
    } t_result;

endpackage

/* src/sbfp_parse.sv */
// next-state and result logic for one received byte
// depends on sbfp_pkg
module sbfp_parse (
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_payload_length,
    input  sbfp_pkg::t_parse_state i_state,
    output sbfp_pkg::t_parse_state o_state,
    output sbfp_pkg::t_result      o_result
);

    logic [7:0] calc_sum;
    logic [7:0] count_inc;

    assign calc_sum  = i_state.length + i_state.address + i_state.command + i_state.sum;
    assign count_inc = i_state.count + 8'd1;

    // phase walk over the frame
    always_comb begin
        o_state = i_state;
        o_result.payload_valid = 1'b0;
        o_result.payload_byte  = 8'd0;
        o_result.payload_index = 8'd0;
        o_result.frame_done    = 1'b0;
        o_result.checksum_ok   = 1'b0;
        if (i_rx_byte == sbfp_pkg::HEADER_BYTE) begin
            o_state.phase = sbfp_pkg::PH_LEN;
        end else begin
            unique case (i_state.phase)
                sbfp_pkg::PH_LEN: begin
                    o_state.length = i_rx_byte;
                    o_state.phase  = sbfp_pkg::PH_ADDR;
                end
                sbfp_pkg::PH_ADDR: begin
                    o_state.address = i_rx_byte;
                    o_state.phase   = sbfp_pkg::PH_CMD;
                end
                sbfp_pkg::PH_CMD: begin
                    o_state.command = i_rx_byte;
                    o_state.count   = 8'd0;
                    o_state.sum     = 8'd0;
                    o_state.phase   = sbfp_pkg::PH_DATA;
                end
                sbfp_pkg::PH_DATA: begin
                    // bytes past the expected count are dropped
                    if (i_state.count < i_payload_length) begin
                        o_result.payload_valid = 1'b1;
                        o_result.payload_byte  = i_rx_byte;
                        o_result.payload_index = i_state.count;
                        o_state.sum            = i_state.sum + i_rx_byte;
                        o_state.count          = count_inc;
                        if (count_inc == i_payload_length) begin
                            o_state.count = 8'd0;
                            o_state.phase = sbfp_pkg::PH_SUM;
                        end
                    end
                end
                sbfp_pkg::PH_SUM: begin
                    o_result.frame_done  = 1'b1;
                    o_result.checksum_ok = (calc_sum == i_rx_byte);
                    o_state.phase        = sbfp_pkg::PH_IDLE;
                end
                default: begin
                    o_state.phase = sbfp_pkg::PH_IDLE;
                end
            endcase
        end
        o_result.frame_address = o_state.address;
        o_result.frame_command = o_state.command;
        o_result.frame_length  = o_state.length;
    end

endmodule

/* src/sync_byte_frame_parser.sv */
// top level of the byte frame parser: register port, state and result register
// depends on sbfp_pkg, sbfp_parse and sync_byte_frame_parser_defines.svh
//
// Usage:
//   Input channel: one received byte per beat on i_rx_byte, i_in_valid/o_in_ready.
//   Output channel: one result beat per input beat, o_out_valid/i_out_ready,
//   carrying payload byte and index, frame done, checksum status and the
//   kept length, address and command fields.
//   A byte 0x68 anywhere starts a new frame; the payload size comes from the
//   payload_length register at byte address 0 of the APB-style port.
//   Latency: the result of a byte is on the output the cycle after it is taken.
//   Throughput: one byte per cycle while the output is not stalled; the state update
//   is combinational, from the state registers to the state and result registers.
//   Stall: while a result waits and i_out_ready is low, o_in_ready drops;
//   when the waiting result is taken, a new byte can be taken in the same cycle.
//   Reset: synchronous, active low; parser goes idle, kept fields clear to 0,
//   payload_length returns to 9 and the output register empties.
`include "sync_byte_frame_parser_defines.svh"

module sync_byte_frame_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    // result output
    output logic                                o_payload_valid,
    output logic [7:0]                          o_payload_byte,
    output logic [7:0]                          o_payload_index,
    output logic                                o_frame_done,
    output logic                                o_checksum_ok,
    output logic [7:0]                          o_frame_address,
    output logic [7:0]                          o_frame_command,
    output logic [7:0]                          o_frame_length,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbfp_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [7:0]             r_payload_length;
    sbfp_pkg::t_parse_state r_state;
    sbfp_pkg::t_parse_state n_state;
    sbfp_pkg::t_result      r_out;
    sbfp_pkg::t_result      n_out;
    logic                   r_out_valid;
    logic                   in_accept;
    logic                   reg_write;
    logic                   reg_sel_len;

    // register port decode
    assign pready      = 1'b1;
    assign reg_sel_len = (paddr[sbfp_pkg::REG_ADDR_W-1:2] == sbfp_pkg::REG_PAYLOAD_LEN);
    assign reg_write   = psel && penable && pwrite && pready;
    assign prdata      = reg_sel_len ? {24'd0, r_payload_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= sbfp_pkg::PAYLOAD_LEN_RST;
        end else begin
            if (reg_write && reg_sel_len) begin
                r_payload_length <= pwdata[7:0];
            end
        end
    end

    // per-byte parse logic
    sbfp_parse u_parse (
        .i_rx_byte        (i_rx_byte),
        .i_payload_length (r_payload_length),
        .i_state          (r_state),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    // accept a byte whenever the result register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= sbfp_pkg::PH_IDLE;
            r_state.length  <= 8'd0;
            r_state.address <= 8'd0;
            r_state.command <= 8'd0;
            r_state.sum     <= 8'd0;
            r_state.count   <= 8'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
                r_out   <= n_out;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_frame_done    = r_out.frame_done;
    assign o_checksum_ok   = r_out.checksum_ok;
    assign o_frame_address = r_out.frame_address;
    assign o_frame_command = r_out.frame_command;
    assign o_frame_length  = r_out.frame_length;

    // checks on the parser and result register
    `SBFP_ASSERT(a_done_goes_idle, in_accept && n_out.frame_done |=> r_state.phase == sbfp_pkg::PH_IDLE)
    `SBFP_ASSERT_NEVER(a_ok_without_done, r_out_valid && r_out.checksum_ok && !r_out.frame_done)
    `SBFP_ASSERT_NEVER(a_done_and_payload, r_out_valid && r_out.frame_done && r_out.payload_valid)
    `SBFP_ASSERT(a_stall_holds, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))

endmodule
